FILE: design/dfs_maze_carver_macros.svh
// Assertion macros used by the maze carver top level.
`ifndef DFS_MAZE_CARVER_MACROS_SVH
`define DFS_MAZE_CARVER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dmc_pkg.sv
`timescale 1ns / 1ps
// Package with the microcode format, the control program and shared codes of the maze carver.
package dmc_pkg;

  localparam int PCW = 5;

  localparam logic [1:0] DIR_TOP    = 2'd0;
  localparam logic [1:0] DIR_BOTTOM = 2'd1;
  localparam logic [1:0] DIR_LEFT   = 2'd2;
  localparam logic [1:0] DIR_RIGHT  = 2'd3;

  localparam logic [PCW-1:0] S_BOOT   = 5'd0;
  localparam logic [PCW-1:0] S_BOOTJ  = 5'd1;
  localparam logic [PCW-1:0] S_IDLE   = 5'd2;
  localparam logic [PCW-1:0] S_DISP   = 5'd3;
  localparam logic [PCW-1:0] S_FINCK  = 5'd4;
  localparam logic [PCW-1:0] S_START  = 5'd5;
  localparam logic [PCW-1:0] S_LDST   = 5'd6;
  localparam logic [PCW-1:0] S_RED    = 5'd7;
  localparam logic [PCW-1:0] S_MARK   = 5'd8;
  localparam logic [PCW-1:0] S_PROBE  = 5'd9;
  localparam logic [PCW-1:0] S_CAPT   = 5'd10;
  localparam logic [PCW-1:0] S_BR     = 5'd11;
  localparam logic [PCW-1:0] S_CARVE  = 5'd12;
  localparam logic [PCW-1:0] S_POP    = 5'd13;
  localparam logic [PCW-1:0] S_POPLD  = 5'd14;
  localparam logic [PCW-1:0] S_PROBE2 = 5'd15;
  localparam logic [PCW-1:0] S_CAPT2  = 5'd16;
  localparam logic [PCW-1:0] S_POPBR  = 5'd17;
  localparam logic [PCW-1:0] S_FOUND  = 5'd18;
  localparam logic [PCW-1:0] S_FINISH = 5'd19;
  localparam logic [PCW-1:0] S_EMIT   = 5'd20;
  localparam logic [PCW-1:0] S_RET    = 5'd21;
  localparam logic [PCW-1:0] S_CLR    = 5'd22;
  localparam logic [PCW-1:0] S_CLRW   = 5'd23;
  localparam logic [PCW-1:0] S_CLRJ   = 5'd24;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_RES_ZERO,
    A_LOAD_START,
    A_REDUCE,
    A_MARK_PUSH,
    A_PROBE,
    A_CAPT,
    A_CARVE,
    A_POP_RD,
    A_POP_LD,
    A_TAKE,
    A_FINISH,
    A_EMIT,
    A_RESTART,
    A_CLR_WR
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_XFER,
    C_CMD,
    C_FIN,
    C_NOT_START,
    C_RED_GE,
    C_D_MORE,
    C_MASK_ZERO,
    C_SC_ZERO,
    C_OUT_BUSY,
    C_CLR_MORE
  } cond_e;

  typedef struct packed {
    act_e           act;
    cond_e          cond;
    logic [PCW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic cmd;
    logic finished;
    logic at_start;
    logic red_ge;
    logic d_more;
    logic mask_zero;
    logic sc_zero;
    logic out_busy;
    logic clr_more;
  } stat_t;

  function automatic uword_t uw(input act_e a, input cond_e c, input logic [PCW-1:0] t);
    uword_t w;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [PCW-1:0] pc);
    uword_t w;
    case (pc)
      S_BOOT:   w = uw(A_CLR_WR,     C_CLR_MORE,  S_BOOT);
      S_BOOTJ:  w = uw(A_NONE,       C_ALWAYS,    S_IDLE);
      S_IDLE:   w = uw(A_ACCEPT,     C_NO_XFER,   S_IDLE);
      S_DISP:   w = uw(A_RES_ZERO,   C_CMD,       S_CLR);
      S_FINCK:  w = uw(A_NONE,       C_FIN,       S_EMIT);
      S_START:  w = uw(A_NONE,       C_NOT_START, S_MARK);
      S_LDST:   w = uw(A_LOAD_START, C_NEVER,     S_IDLE);
      S_RED:    w = uw(A_REDUCE,     C_RED_GE,    S_RED);
      S_MARK:   w = uw(A_MARK_PUSH,  C_NEVER,     S_IDLE);
      S_PROBE:  w = uw(A_PROBE,      C_NEVER,     S_IDLE);
      S_CAPT:   w = uw(A_CAPT,       C_D_MORE,    S_PROBE);
      S_BR:     w = uw(A_NONE,       C_MASK_ZERO, S_POP);
      S_CARVE:  w = uw(A_CARVE,      C_ALWAYS,    S_EMIT);
      S_POP:    w = uw(A_POP_RD,     C_SC_ZERO,   S_FINISH);
      S_POPLD:  w = uw(A_POP_LD,     C_NEVER,     S_IDLE);
      S_PROBE2: w = uw(A_PROBE,      C_NEVER,     S_IDLE);
      S_CAPT2:  w = uw(A_CAPT,       C_D_MORE,    S_PROBE2);
      S_POPBR:  w = uw(A_NONE,       C_MASK_ZERO, S_POP);
      S_FOUND:  w = uw(A_TAKE,       C_ALWAYS,    S_EMIT);
      S_FINISH: w = uw(A_FINISH,     C_NEVER,     S_IDLE);
      S_EMIT:   w = uw(A_EMIT,       C_OUT_BUSY,  S_EMIT);
      S_RET:    w = uw(A_NONE,       C_ALWAYS,    S_IDLE);
      S_CLR:    w = uw(A_RESTART,    C_NEVER,     S_IDLE);
      S_CLRW:   w = uw(A_CLR_WR,     C_CLR_MORE,  S_CLRW);
      S_CLRJ:   w = uw(A_NONE,       C_ALWAYS,    S_EMIT);
      default:  w = uw(A_NONE,       C_ALWAYS,    S_IDLE);
    endcase
    return w;
  endfunction

endpackage

FILE: design/dfs_maze_carver.sv
`timescale 1ns / 1ps
`include "dfs_maze_carver_macros.svh"
// Top level of the depth-first maze carver with stream ports and a start cell register.
//
// The block carves a maze over a SIDE by SIDE grid, one step per input transfer, and returns
// exactly one result transfer per input. A small control program steps a datapath that holds
// the visited map and the path stack in two memories. The visited memory has one read port, so
// each of the four neighbor checks takes a probe state, which reads the memory and registers
// the bound check, and a capture state. The first step after reset or restart also loads the
// start index and reduces it by SIDE per row to find the start cell, and each cell popped
// while backtracking is probed again in the same way. After reset, and on every restart
// command, the visited memory is cleared one entry per cycle, all 4 to the power of
// ceil(log2(SIDE)) entries (256 for a 16 by 16 grid); no input is taken meanwhile, while
// start cell writes are accepted at any time. A new input is taken while the previous result
// still waits on the output side.
module dfs_maze_carver import dmc_pkg::*; #(
  parameter int SIDE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // random_value
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // carved, from_cell, direction, to_cell, done_res,
                                      // exit_opened, zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  stat_t          stat;
  act_e           act;
  logic [PCW-1:0] pc;

  logic           res_carved;
  logic [7:0]     res_from;
  logic [1:0]     res_dir;
  logic [7:0]     res_to;
  logic           res_done;
  logic           res_exit;
  logic           in_xfer;
  logic           bottom_carve;

  dmc_useq u_useq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .act_o (act),
    .pc_o  (pc)
  );

  dmc_dpath #(
    .SIDE(SIDE)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .act_i        (act),
    .stat_o       (stat),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  assign res_carved   = m_axis_tdata[0];
  assign res_from     = m_axis_tdata[8:1];
  assign res_dir      = m_axis_tdata[10:9];
  assign res_to       = m_axis_tdata[18:11];
  assign res_done     = m_axis_tdata[19];
  assign res_exit     = m_axis_tdata[20];
  assign in_xfer      = s_axis_tvalid && s_axis_tready;
  assign bottom_carve = m_axis_tvalid && res_carved && (res_dir == DIR_BOTTOM);

  `DMC_ASSERT_IMP(a_exit_done, m_axis_tvalid && res_exit, res_done, "Exit opened without done.")
  `DMC_ASSERT_IMP(a_carve_exit, m_axis_tvalid, !(res_carved && res_exit), "Carve with exit.")
  `DMC_ASSERT_NXT(a_accept_dispatch, in_xfer, pc == S_DISP, "Accepted input not dispatched.")
  `DMC_ASSERT_IMP(a_bottom_step, bottom_carve, res_to == 8'(res_from + 8'(SIDE)), "Bad bottom.")

endmodule

FILE: design/dmc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/dmc_useq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module dmc_useq import dmc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stat_t          stat_i,
  output act_e           act_o,
  output logic [PCW-1:0] pc_o
);

  logic [PCW-1:0] pc_q, pc_d;
  uword_t         word;
  logic           taken;

  assign word  = ucode(pc_q);
  assign act_o = word.act;
  assign pc_o  = pc_q;

  always_comb begin
    case (word.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_XFER:   taken = !stat_i.in_valid;
      C_CMD:       taken = stat_i.cmd;
      C_FIN:       taken = stat_i.finished;
      C_NOT_START: taken = !stat_i.at_start;
      C_RED_GE:    taken = stat_i.red_ge;
      C_D_MORE:    taken = stat_i.d_more;
      C_MASK_ZERO: taken = stat_i.mask_zero;
      C_SC_ZERO:   taken = stat_i.sc_zero;
      C_OUT_BUSY:  taken = stat_i.out_busy;
      C_CLR_MORE:  taken = stat_i.clr_more;
      default:     taken = 1'b0;
    endcase
  end

  assign pc_d = taken ? word.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_BOOT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: design/dmc_dpath.sv
`timescale 1ns / 1ps
// Datapath of the maze carver: cell registers, visited and path memories, result register.
module dmc_dpath import dmc_pkg::*; #(
  parameter int SIDE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  act_e        act_i,
  output stat_t       stat_o,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int RW     = $clog2(SIDE);
  localparam int AW     = 2 * RW;
  localparam int VDEPTH = 1 << AW;
  localparam int CELLS  = SIDE * SIDE;
  localparam int SAW    = $clog2(CELLS);
  localparam int SCW    = SAW + 1;

  logic [7:0]     start_q;
  logic           cmd_q;
  logic [7:0]     rv_q;
  logic [RW-1:0]  cur_r_q, cur_c_q;
  logic [RW-1:0]  pb_r_q, pb_c_q;
  logic [7:0]     red_q;
  logic [1:0]     d_q;
  logic           ok_q;
  logic [3:0]     mask_q;
  logic [SCW-1:0] sc_q;
  logic           at_start_q;
  logic           fin_q;
  logic [AW-1:0]  clr_q;
  logic           res_carved_q;
  logic [7:0]     res_from_q;
  logic [1:0]     res_dir_q;
  logic [7:0]     res_to_q;
  logic           res_exit_q;
  logic           out_valid_q;
  logic [23:0]    out_data_q;

  logic [AW:0]    probe_nb;
  logic [AW:0]    carve_nb;
  logic [2:0]     cnt_k;
  logic [10:0]    prod;
  logic [1:0]     pick;
  logic [1:0]     dsel;
  logic           out_busy;
  logic           stk_full;
  logic [SCW-1:0] sc_dec;

  logic           vis_we;
  logic [AW-1:0]  vis_waddr;
  logic           vis_wdata;
  logic           vis_rdata;
  logic           stk_we;
  logic [AW-1:0]  stk_rdata;

  function automatic logic [AW:0] nbr(input logic [RW-1:0] r, input logic [RW-1:0] c,
                                      input logic [1:0] d);
    logic          ok;
    logic [RW-1:0] nr;
    logic [RW-1:0] nc;
    ok = 1'b0;
    nr = r;
    nc = c;
    case (d)
      DIR_TOP: begin
        ok = (r != '0);
        nr = r - 1'b1;
      end
      DIR_BOTTOM: begin
        ok = (r != RW'(SIDE - 1));
        nr = r + 1'b1;
      end
      DIR_LEFT: begin
        ok = (c != '0);
        nc = c - 1'b1;
      end
      DIR_RIGHT: begin
        ok = (c != RW'(SIDE - 1));
        nc = c + 1'b1;
      end
      default: ok = 1'b0;
    endcase
    return {ok, nr, nc};
  endfunction

  function automatic logic [7:0] cell_of(input logic [RW-1:0] r, input logic [RW-1:0] c);
    logic [AW-1:0] idx;
    idx = AW'(AW'(r) * AW'(SIDE) + AW'(c));
    return 8'(idx);
  endfunction

  assign probe_nb = nbr(pb_r_q, pb_c_q, d_q);

  assign cnt_k = 3'($countones(mask_q));
  assign prod  = 11'(rv_q) * 11'(cnt_k);
  assign pick  = prod[9:8];

  always_comb begin
    logic [1:0] cnt;
    logic       found;
    cnt   = 2'd0;
    found = 1'b0;
    dsel  = DIR_TOP;
    for (int i = 0; i < 4; i++) begin
      if (mask_q[i] && !found) begin
        if (cnt == pick) begin
          dsel  = 2'(i);
          found = 1'b1;
        end
        cnt = cnt + 1'b1;
      end
    end
  end

  assign carve_nb = nbr(pb_r_q, pb_c_q, dsel);

  assign out_busy = out_valid_q && !m_axis_tready;
  assign stk_full = (sc_q == SCW'(CELLS));
  assign sc_dec   = sc_q - 1'b1;

  assign s_axis_tready = (act_i == A_ACCEPT);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign vis_we    = (act_i == A_MARK_PUSH) || (act_i == A_CLR_WR);
  assign vis_waddr = (act_i == A_MARK_PUSH) ? {cur_r_q, cur_c_q} : clr_q;
  assign vis_wdata = (act_i == A_MARK_PUSH);
  assign stk_we    = (act_i == A_MARK_PUSH) && !stk_full;

  dmc_ram #(
    .WIDTH(1),
    .DEPTH(VDEPTH)
  ) u_visited (
    .clk_i  (clk_i),
    .we_i   (vis_we),
    .waddr_i(vis_waddr),
    .wdata_i(vis_wdata),
    .raddr_i(probe_nb[AW-1:0]),
    .rdata_o(vis_rdata)
  );

  dmc_ram #(
    .WIDTH(AW),
    .DEPTH(CELLS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(sc_q[SAW-1:0]),
    .wdata_i({cur_r_q, cur_c_q}),
    .raddr_i(sc_dec[SAW-1:0]),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    stat_o.in_valid  = s_axis_tvalid;
    stat_o.cmd       = cmd_q;
    stat_o.finished  = fin_q;
    stat_o.at_start  = at_start_q;
    stat_o.red_ge    = (red_q >= 8'(SIDE));
    stat_o.d_more    = (d_q != 2'd3);
    stat_o.mask_zero = (mask_q == 4'd0);
    stat_o.sc_zero   = (sc_q == '0);
    stat_o.out_busy  = out_busy;
    stat_o.clr_more  = (clr_q != AW'(VDEPTH - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 8'd0;
      cur_r_q     <= '0;
      cur_c_q     <= '0;
      sc_q        <= '0;
      at_start_q  <= 1'b1;
      fin_q       <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        start_q <= cfg_data_i;
      end
      if (act_i == A_EMIT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (act_i)
        A_LOAD_START: begin
          cur_r_q    <= '0;
          at_start_q <= 1'b0;
        end
        A_REDUCE: begin
          if (red_q >= 8'(SIDE)) begin
            cur_r_q <= (cur_r_q == RW'(SIDE - 1)) ? '0 : cur_r_q + 1'b1;
          end else begin
            cur_c_q <= red_q[RW-1:0];
          end
        end
        A_MARK_PUSH: begin
          if (!stk_full) begin
            sc_q <= sc_q + 1'b1;
          end
        end
        A_CARVE: begin
          cur_r_q <= carve_nb[AW-1:RW];
          cur_c_q <= carve_nb[RW-1:0];
        end
        A_POP_RD: begin
          if (sc_q != '0) begin
            sc_q <= sc_dec;
          end
        end
        A_TAKE: begin
          cur_r_q <= pb_r_q;
          cur_c_q <= pb_c_q;
        end
        A_FINISH: fin_q <= 1'b1;
        A_RESTART: begin
          sc_q       <= '0;
          at_start_q <= 1'b1;
          fin_q      <= 1'b0;
          clr_q      <= '0;
        end
        A_CLR_WR: clr_q <= clr_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i == A_EMIT && !out_busy) begin
      out_data_q <= {3'b000, res_exit_q, fin_q, res_to_q, res_dir_q, res_from_q, res_carved_q};
    end
    case (act_i)
      A_ACCEPT: begin
        if (s_axis_tvalid) begin
          cmd_q <= s_axis_tuser;
          rv_q  <= s_axis_tdata;
        end
      end
      A_RES_ZERO: begin
        res_carved_q <= 1'b0;
        res_from_q   <= 8'd0;
        res_dir_q    <= DIR_TOP;
        res_to_q     <= 8'd0;
        res_exit_q   <= 1'b0;
      end
      A_LOAD_START: red_q <= start_q;
      A_REDUCE: begin
        if (red_q >= 8'(SIDE)) begin
          red_q <= red_q - 8'(SIDE);
        end
      end
      A_MARK_PUSH: begin
        pb_r_q <= cur_r_q;
        pb_c_q <= cur_c_q;
        d_q    <= 2'd0;
        mask_q <= 4'd0;
      end
      A_PROBE: ok_q <= probe_nb[AW];
      A_CAPT: begin
        mask_q[d_q] <= ok_q && !vis_rdata;
        d_q         <= d_q + 1'b1;
      end
      A_CARVE: begin
        res_carved_q <= 1'b1;
        res_from_q   <= cell_of(pb_r_q, pb_c_q);
        res_dir_q    <= dsel;
        res_to_q     <= cell_of(carve_nb[AW-1:RW], carve_nb[RW-1:0]);
      end
      A_POP_LD: begin
        pb_r_q <= stk_rdata[AW-1:RW];
        pb_c_q <= stk_rdata[RW-1:0];
        d_q    <= 2'd0;
        mask_q <= 4'd0;
      end
      A_FINISH: begin
        res_exit_q <= 1'b1;
        res_from_q <= 8'(CELLS - 1);
        res_dir_q  <= DIR_RIGHT;
        res_to_q   <= 8'd0;
      end
      default: ;
    endcase
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the depth-first maze carver, with its own step predictor.
module testbench;
  import dmc_pkg::*;

  localparam int SIDE  = 16;
  localparam int CELLS = SIDE * SIDE;

  typedef struct packed {
    logic [2:0] fill;
    logic       exit_opened;
    logic       done_res;
    logic [7:0] to_cell;
    logic [1:0] direction;
    logic [7:0] from_cell;
    logic       carved;
  } step_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  bit           visited_q [CELLS];
  int           trail_q [CELLS];
  int           trail_depth;
  int           cur_cell;
  bit           fresh_start;
  bit           maze_done;
  logic [7:0]   start_reg;
  step_result_t pending_carves [$];
  int           mismatches;
  bit           no_idle;
  bit           feeding;
  int           ready_hold;

  dfs_maze_carver #(.SIDE(SIDE)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("** dfs_maze_carver: FAILED **");
    $finish;
  end

  function automatic int free_neighbors(input int c, output int cell_o [4],
                                        output logic [1:0] dir_o [4]);
    int         row;
    int         col;
    int         k;
    int         cand [4];
    bit         ok [4];
    logic [1:0] code [4];
    row = c / SIDE;
    col = c % SIDE;
    k = 0;
    ok[0] = row > 0;        cand[0] = c - SIDE; code[0] = DIR_TOP;
    ok[1] = row < SIDE - 1; cand[1] = c + SIDE; code[1] = DIR_BOTTOM;
    ok[2] = col > 0;        cand[2] = c - 1;    code[2] = DIR_LEFT;
    ok[3] = col < SIDE - 1; cand[3] = c + 1;    code[3] = DIR_RIGHT;
    for (int d = 0; d < 4; d++) begin
      if (ok[d] && cand[d] < CELLS && !visited_q[cand[d]]) begin
        cell_o[k] = cand[d];
        dir_o[k] = code[d];
        k++;
      end
    end
    return k;
  endfunction

  function automatic step_result_t next_carve_result(input logic cmd, input logic [7:0] rv);
    step_result_t r;
    int           nb_cell [4];
    logic [1:0]   nb_dir [4];
    int           k;
    int           pick;
    int           c;
    bit           found;
    r = '0;
    if (cmd) begin
      foreach (visited_q[i]) visited_q[i] = 1'b0;
      trail_depth = 0;
      fresh_start = 1'b1;
      maze_done = 1'b0;
    end else if (!maze_done) begin
      if (fresh_start) begin
        cur_cell = int'(start_reg) % CELLS;
        fresh_start = 1'b0;
      end
      cur_cell = cur_cell % CELLS;
      visited_q[cur_cell] = 1'b1;
      if (trail_depth < CELLS) begin
        trail_q[trail_depth] = cur_cell;
        trail_depth++;
      end
      k = free_neighbors(cur_cell, nb_cell, nb_dir);
      if (k > 0) begin
        pick = (int'(rv) * k) >> 8;
        r.carved = 1'b1;
        r.from_cell = cur_cell[7:0];
        r.direction = nb_dir[pick];
        r.to_cell = nb_cell[pick][7:0];
        cur_cell = nb_cell[pick];
      end else begin
        found = 1'b0;
        while (trail_depth > 0 && !found) begin
          trail_depth--;
          c = trail_q[trail_depth] % CELLS;
          if (free_neighbors(c, nb_cell, nb_dir) > 0) begin
            cur_cell = c;
            found = 1'b1;
          end
        end
      end
      if (free_neighbors(cur_cell, nb_cell, nb_dir) == 0 && trail_depth == 0) begin
        maze_done = 1'b1;
        r.exit_opened = 1'b1;
        r.from_cell = 8'(CELLS - 1);
        r.direction = DIR_RIGHT;
        r.to_cell = 8'd0;
      end
    end
    r.done_res = maze_done;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(input logic [23:0] data);
    step_result_t got;
    step_result_t want;
    got = data;
    if (pending_carves.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, data);
      mismatches++;
    end else begin
      want = pending_carves.pop_front();
      check_field("carved", want.carved, got.carved);
      check_field("from_cell", want.from_cell, got.from_cell);
      check_field("direction", want.direction, got.direction);
      check_field("to_cell", want.to_cell, got.to_cell);
      check_field("done_res", want.done_res, got.done_res);
      check_field("exit_opened", want.exit_opened, got.exit_opened);
      check_field("fill", want.fill, got.fill);
    end
  endfunction

  // After each transfer the receiver holds tready low for a randomly drawn hold, none with no_idle set.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
      ready_hold = no_idle ? 0 : $urandom_range(0, 16);
    end else if (ready_hold > 0) begin
      ready_hold--;
    end
    m_axis_tready <= (ready_hold == 0);
  end

  task automatic send_step(input logic cmd, input logic [7:0] rv);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0 && feeding) begin
      s_axis_tvalid <= 1'b0;
      feeding = 1'b0;
    end
    repeat (gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rv;
    s_axis_tuser <= cmd;
    feeding = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_carves.push_back(next_carve_result(cmd, rv));
  endtask

  task automatic wait_drained();
    if (feeding) begin
      s_axis_tvalid <= 1'b0;
      feeding = 1'b0;
    end
    while (pending_carves.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [7:0] cell_idx);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cell_idx;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    start_reg = cell_idx;
  endtask

  function automatic logic [7:0] pick_random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_corner_starts();
    write_start(8'd255);
    send_step(1'b0, 8'h00);
    send_step(1'b0, 8'hff);
    send_step(1'b0, 8'h80);
    send_step(1'b1, 8'hff);
    wait_drained();
    write_start(8'd0);
    send_step(1'b1, 8'h00);
    send_step(1'b0, 8'hff);
    send_step(1'b0, 8'h00);
    send_step(1'b0, 8'h55);
    send_step(1'b0, 8'haa);
    send_step(1'b1, 8'h00);
    wait_drained();
    write_start(8'd136);
    send_step(1'b0, 8'h00);
    send_step(1'b0, 8'h40);
    send_step(1'b0, 8'h80);
    send_step(1'b0, 8'hc0);
    send_step(1'b0, 8'hff);
    send_step(1'b1, 8'h00);
    wait_drained();
    write_start(8'd15);
    send_step(1'b0, 8'hff);
    send_step(1'b0, 8'h00);
    send_step(1'b1, 8'h00);
    wait_drained();
    write_start(8'd240);
    send_step(1'b0, 8'h00);
    send_step(1'b0, 8'hff);
    send_step(1'b1, 8'h00);
  endtask

  // Each maze is carved to completion, stepped a few times past the end, then restarted.
  task automatic test_full_mazes();
    for (int m = 0; m < 2; m++) begin
      wait_drained();
      write_start(m == 0 ? 8'd0 : 8'd255);
      no_idle = (m == 1);
      while (!maze_done) send_step(1'b0, pick_random_byte());
      repeat (3) send_step(1'b0, pick_random_byte());
      send_step(1'b1, pick_random_byte());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_restarts();
    for (int n = 0; n < 300; n++) begin
      if (n % 100 == 50) no_idle = ~no_idle;
      if ($urandom_range(0, 49) == 0) begin
        wait_drained();
        write_start(8'($urandom_range(0, 255)));
      end
      send_step($urandom_range(0, 29) == 0, pick_random_byte());
    end
    no_idle = 1'b0;
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** dfs_maze_carver: PASSED **");
    end else begin
      $display("** dfs_maze_carver: FAILED **");
    end
    $finish;
  endtask

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h00;
    s_axis_tuser <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= 8'h00;
    foreach (visited_q[i]) visited_q[i] = 1'b0;
    foreach (trail_q[i]) trail_q[i] = 0;
    trail_depth = 0;
    cur_cell = 0;
    fresh_start = 1'b1;
    maze_done = 1'b0;
    start_reg = 8'h00;
    no_idle = 1'b0;
    feeding = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_corner_starts();
    test_full_mazes();
    test_random_restarts();
    finish_run();
  end

endmodule

FILE: sim.f
+incdir+design
design/dmc_pkg.sv
design/dmc_ram.sv
design/dmc_useq.sv
design/dmc_dpath.sv
design/dfs_maze_carver.sv
verif/testbench.sv
